// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Types, codes and code-page helpers of the text codepage transcoder.
// ----------------------------------------------------------------------------
package tct_pkg;

  localparam logic [1:0] CFG_IN_CODE  = 2'd0;
  localparam logic [1:0] CFG_OUT_CODE = 2'd1;
  localparam logic [1:0] CFG_OUT_CAP  = 2'd2;

  localparam logic [1:0] IN_RAW    = 2'd0;
  localparam logic [1:0] IN_UTF8   = 2'd1;
  localparam logic [1:0] IN_CP1251 = 2'd2;
  localparam logic [1:0] IN_U16LE  = 2'd3;

  localparam logic [2:0] OUT_RAW    = 3'd0;
  localparam logic [2:0] OUT_UTF8   = 3'd1;
  localparam logic [2:0] OUT_CP1251 = 3'd2;
  localparam logic [2:0] OUT_U16LE  = 3'd3;
  localparam logic [2:0] OUT_U16BE  = 3'd4;

  typedef struct packed {
    logic [1:0]  in_code;
    logic [2:0]  out_code;
    logic [15:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ch;
    logic        have;
    logic        last;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic       full;
  } fifo_stat_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } enc_t;

  function automatic logic [15:0] cp1251_decode(logic [7:0] b);
    logic [15:0] v;
    v = {8'h00, b};
    if (b >= 8'hC0) begin
      v = {8'h00, b} - 16'h00C0 + 16'h0410;
    end else begin
      unique case (b)
        8'hB2:   v = 16'h0406;
        8'hAF:   v = 16'h0407;
        8'hB3:   v = 16'h0456;
        8'hBF:   v = 16'h0457;
        default: v = {8'h00, b};
      endcase
    end
    return v;
  endfunction

  function automatic logic [7:0] cp1251_encode(logic [15:0] v);
    logic [15:0] d;
    logic [7:0]  b;
    d = v - 16'h0410;
    b = v[7:0];
    if (v >= 16'h0410 && v <= 16'h044F) begin
      b = d[7:0] + 8'hC0;
    end else begin
      unique case (v)
        16'h0406: b = 8'hB2;
        16'h0407: b = 8'hAF;
        16'h0456: b = 8'hB3;
        16'h0457: b = 8'hBF;
        default:  b = v[7:0];
      endcase
    end
    return b;
  endfunction

  function automatic enc_t tct_encode(logic [15:0] v, logic [2:0] code);
    enc_t e;
    e = '{cnt: 2'd1, b0: v[7:0], b1: 8'h00, b2: 8'h00};
    unique case (code)
      OUT_UTF8: begin
        if (v < 16'h0080) begin
          e.cnt = 2'd1;
          e.b0  = v[7:0];
        end else if (v < 16'h0800) begin
          e.cnt = 2'd2;
          e.b0  = {3'b110, v[10:6]};
          e.b1  = {2'b10, v[5:0]};
        end else begin
          e.cnt = 2'd3;
          e.b0  = {4'b1110, v[15:12]};
          e.b1  = {2'b10, v[11:6]};
          e.b2  = {2'b10, v[5:0]};
        end
      end
      OUT_CP1251: begin
        e.cnt = 2'd1;
        e.b0  = cp1251_encode(v);
      end
      OUT_U16LE: begin
        e.cnt = 2'd2;
        e.b0  = v[7:0];
        e.b1  = v[15:8];
      end
      OUT_U16BE: begin
        e.cnt = 2'd2;
        e.b0  = v[15:8];
        e.b1  = v[7:0];
      end
      default: begin
        e.cnt = 2'd1;
        e.b0  = v[7:0];
      end
    endcase
    return e;
  endfunction

endpackage

// File: rtl/tct_front.sv
// ----------------------------------------------------------------------------
// tct_front
// Input decoder: accepts bytes, assembles characters, queues character jobs.
// ----------------------------------------------------------------------------
module tct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_code,
  input  logic              dec_clr,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // in_byte
  input  logic              in_tlast,   // last_in
  input  tct_pkg::fifo_stat_t q_stat,
  output logic              q_push,
  output tct_pkg::job_t     q_job
);
  import tct_pkg::*;

  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [15:0] ch;
  logic        have;
  logic        accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    ch       = 16'h0000;
    have     = 1'b0;
    if (pend_r != 2'd0) begin
      if (in_code == IN_U16LE) begin
        ch = acc_r | {in_tdata, 8'h00};
      end else begin
        ch = {acc_r[9:0], 6'b0} + {8'h00, in_tdata} - 16'h0080;
      end
      pend_nxt = pend_r - 2'd1;
      if (pend_nxt == 2'd0) begin
        have = 1'b1;
      end else begin
        acc_nxt = ch;
      end
    end else begin
      unique case (in_code)
        IN_UTF8: begin
          if (in_tdata >= 8'hC0 && in_tdata <= 8'hDF) begin
            acc_nxt  = {11'b0, in_tdata[4:0]};
            pend_nxt = 2'd1;
          end else if (in_tdata >= 8'hE0 && in_tdata <= 8'hEF) begin
            acc_nxt  = {12'b0, in_tdata[3:0]};
            pend_nxt = 2'd2;
          end else begin
            ch   = {8'h00, in_tdata};
            have = 1'b1;
          end
        end
        IN_CP1251: begin
          ch   = cp1251_decode(in_tdata);
          have = 1'b1;
        end
        IN_U16LE: begin
          acc_nxt  = {8'h00, in_tdata};
          pend_nxt = 2'd1;
        end
        default: begin
          ch   = {8'h00, in_tdata};
          have = 1'b1;
        end
      endcase
    end
    if (have) begin
      acc_nxt = 16'h0000;
    end
    if (in_tlast) begin
      acc_nxt  = 16'h0000;
      pend_nxt = 2'd0;
    end
  end

  assign q_push = accept && (have || in_tlast);
  assign q_job  = '{ch: ch, have: have, last: in_tlast};

  always_ff @(posedge clk) begin
    if (!rst_n || dec_clr) begin
      acc_r  <= 16'h0000;
      pend_r <= 2'd0;
    end else if (accept) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: rtl/tct_fifo.sv
// ----------------------------------------------------------------------------
// tct_fifo
// Short job queue between the decoder and the encoder.
// ----------------------------------------------------------------------------
module tct_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tct_pkg::job_t       push_job,
  input  logic                pop,
  output tct_pkg::job_t       head_job,
  output tct_pkg::fifo_stat_t stat
);
  import tct_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == DEPTH_C);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// File: rtl/tct_back.sv
// ----------------------------------------------------------------------------
// tct_back
// Output encoder: expands each job into bytes, one beat per cycle unless out_tready stalls it.
// ----------------------------------------------------------------------------
module tct_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tct_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  tct_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // out_byte
  output logic [1:0]    out_tuser,  // kept, is_terminator
  output logic          out_tlast   // last_out
);
  import tct_pkg::*;

  job_t        job_r;
  logic        job_vld_r;
  logic [2:0]  idx_r;
  logic        chr_en_r;
  logic [15:0] bw_r, bw_nxt;
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;

  enc_t        enc;
  logic        slot_free, chr_en, utf16, step, emit, done, is_term, kept;
  logic [2:0]  ccnt, nterm, total;
  logic [7:0]  byte_sel;

  assign enc       = tct_encode(job_r.ch, cfg.out_code);
  assign slot_free = !out_vld_r || out_tready;
  assign chr_en    = (idx_r == 3'd0) ? (job_r.have && (bw_r < cfg.capacity)) : chr_en_r;
  assign utf16     = (cfg.out_code == OUT_U16LE) || (cfg.out_code == OUT_U16BE);
  assign ccnt      = chr_en ? {1'b0, enc.cnt} : 3'd0;
  assign nterm     = job_r.last ? (utf16 ? 3'd2 : 3'd1) : 3'd0;
  assign total     = ccnt + nterm;
  assign step      = job_vld_r && slot_free;
  assign emit      = step && (total != 3'd0);
  assign done      = (step && (total == 3'd0)) || (emit && (idx_r == total - 3'd1));
  assign is_term   = (idx_r >= ccnt);
  assign kept      = (bw_r < cfg.capacity);
  assign q_pop     = q_valid && (!job_vld_r || done);

  always_comb begin
    unique case (idx_r[1:0])
      2'd0:    byte_sel = enc.b0;
      2'd1:    byte_sel = enc.b1;
      default: byte_sel = enc.b2;
    endcase
    if (is_term) begin
      byte_sel = 8'h00;
    end
  end

  always_comb begin
    bw_nxt = bw_r;
    if (emit) begin
      if (done && job_r.last) begin
        bw_nxt = 16'h0000;
      end else if (bw_r != 16'hFFFF) begin
        bw_nxt = bw_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_byte_r <= byte_sel;
      out_user_r <= {is_term, kept};
      out_last_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= 3'd0;
      chr_en_r  <= 1'b0;
      bw_r      <= 16'h0000;
      out_vld_r <= 1'b0;
    end else begin
      bw_r <= bw_nxt;
      if (q_pop) begin
        job_vld_r <= 1'b1;
      end else if (done) begin
        job_vld_r <= 1'b0;
      end
      if (done) begin
        idx_r <= 3'd0;
      end else if (emit) begin
        idx_r    <= idx_r + 3'd1;
        chr_en_r <= chr_en;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/text_codepage_transcoder_top.sv
// ----------------------------------------------------------------------------
// text_codepage_transcoder_top
// Streaming byte transcoder between raw, UTF-8, CP1251 and UTF-16 codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one input byte per beat, in_tlast on the final byte of a string.
//   out_* : one output byte per beat; out_tuser[0] kept, out_tuser[1] marks
//           a terminator zero, out_tlast closes the bytes of one input beat.
//   cfg_* : write in_code (0), out_code (1), out_capacity (2) while idle;
//           a write to in_code drops any partial character.
// Throughput: an input beat is taken every cycle while the job queue has
//   room; the encoder sends one output byte per cycle while out_tready
//   allows, and takes the next job only when the current one is done; a
//   character dropped past capacity sends no byte.
// Path: each job passes the queue and the job register, then the output register.
// Reset: registers return to in_code 1, out_code 1, capacity 65535, with the
//   decoder, queue and byte count cleared.
// Stall: while out_tready is low the output beat holds; the queue fills
//   and in_tready drops once FIFO_DEPTH jobs wait.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_codepage_transcoder_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic [1:0]  out_tuser,  // kept, is_terminator
  output logic        out_tlast,  // last_out
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import tct_pkg::*;

  cfg_t       cfg_r;
  logic       dec_clr;
  logic       q_push, q_pop;
  job_t       push_job, head_job;
  fifo_stat_t q_stat;
  logic       term_beat, term_first, cap_zero;

  assign dec_clr = cfg_we && (cfg_addr == CFG_IN_CODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_code  <= IN_UTF8;
      cfg_r.out_code <= OUT_UTF8;
      cfg_r.capacity <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IN_CODE:  cfg_r.in_code  <= cfg_wdata[1:0];
        CFG_OUT_CODE: cfg_r.out_code <= cfg_wdata[2:0];
        CFG_OUT_CAP:  cfg_r.capacity <= cfg_wdata;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  tct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_code   (cfg_r.in_code),
    .dec_clr   (dec_clr),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  tct_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  tct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_stat.valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign term_beat  = out_tvalid && out_tuser[1];
  assign term_first = term_beat && out_tready && !out_tlast;
  assign cap_zero   = (cfg_r.capacity == 16'h0000);

  `TCT_ASSERT_NOW(a_term_zero, term_beat, out_tdata == 8'h00, "terminator byte not zero")
  `TCT_ASSERT_NOW(a_cap_zero, out_tvalid && cap_zero, !out_tuser[0], "kept at zero capacity")
  `TCT_ASSERT_NEXT(a_term_pair, term_first, term_beat && out_tlast, "second terminator missing")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_codepage_transcoder_top. Byte beats go in
// through a queue-fed driver, and a clocked transcoder model in the bench
// predicts every output byte with its kept, terminator and last flags.
// Stimulus covers directed code-page corners and random phases of
// well-formed and broken text under changing codes and capacities, with
// random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tct_pkg::*;

  localparam logic [1:0]  CFG_SPARE    = 2'd3;
  localparam logic [2:0]  OUT_SPARE_HI = 3'd7;
  localparam logic [15:0] CAP_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       term;
    logic       last;
  } out_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [15:0] cfg_wdata = 16'h0000;

  in_beat_t  beat_q[$];
  out_byte_t want_q[$];

  int in_max_gap = 0;
  int out_max_gap = 0;
  int feed_gap = 0;
  int sink_stall = 0;
  int errors = 0;
  int beats_in = 0;
  int bytes_out = 0;
  int strings_done = 0;
  int reg_writes = 0;
  int queued_beats = 0;

  logic [1:0]  p_in_code;
  logic [2:0]  p_out_code;
  logic [15:0] p_cap;
  logic [15:0] p_accum;
  logic [1:0]  p_need;
  logic [15:0] p_written;

  text_codepage_transcoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // in_byte
    .in_tlast   (in_tlast),   // last_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_byte
    .out_tuser  (out_tuser),  // kept, is_terminator
    .out_tlast  (out_tlast),  // last_out
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] win_to_ucs(logic [7:0] b);
    if (b >= 8'hC0) return {8'h00, b - 8'hC0} + 16'h0410;
    case (b)
      8'hB2:   return 16'h0406;
      8'hAF:   return 16'h0407;
      8'hB3:   return 16'h0456;
      8'hBF:   return 16'h0457;
      default: return {8'h00, b};
    endcase
  endfunction

  function automatic logic [7:0] ucs_to_win(logic [15:0] v);
    logic [15:0] off;
    off = v - 16'h0410;
    if (v >= 16'h0410 && v <= 16'h044F) return off[7:0] + 8'hC0;
    case (v)
      16'h0406: return 8'hB2;
      16'h0407: return 8'hAF;
      16'h0456: return 8'hB3;
      16'h0457: return 8'hBF;
      default:  return v[7:0];
    endcase
  endfunction

  function automatic void put_byte(logic [7:0] val, logic term);
    out_byte_t r;
    r.data = val;
    r.kept = (p_written < p_cap);
    r.term = term;
    r.last = 1'b0;
    want_q.push_back(r);
    if (p_written != CAP_MAX) p_written++;
  endfunction

  function automatic void transcode_beat(logic [7:0] b, logic last);
    logic [15:0] ch;
    logic        have;
    int          start;
    ch = 16'h0000;
    have = 1'b0;
    start = want_q.size();
    if (p_need != 2'd0) begin
      if (p_in_code == IN_U16LE) ch = p_accum | {b, 8'h00};
      else ch = {p_accum[9:0], 6'd0} + {8'h00, b} - 16'h0080;
      p_need--;
      if (p_need == 2'd0) have = 1'b1;
      else p_accum = ch;
    end else begin
      case (p_in_code)
        IN_UTF8: begin
          if (b >= 8'hC0 && b <= 8'hDF) begin
            p_accum = {8'h00, b - 8'hC0};
            p_need = 2'd1;
          end else if (b >= 8'hE0 && b <= 8'hEF) begin
            p_accum = {8'h00, b - 8'hE0};
            p_need = 2'd2;
          end else begin
            ch = {8'h00, b};
            have = 1'b1;
          end
        end
        IN_CP1251: begin
          ch = win_to_ucs(b);
          have = 1'b1;
        end
        IN_U16LE: begin
          p_accum = {8'h00, b};
          p_need = 2'd1;
        end
        default: begin
          ch = {8'h00, b};
          have = 1'b1;
        end
      endcase
    end

    if (have) begin
      p_accum = 16'h0000;
      if (p_written < p_cap) begin
        case (p_out_code)
          OUT_UTF8: begin
            if (ch < 16'h0080) begin
              put_byte(ch[7:0], 1'b0);
            end else if (ch < 16'h0800) begin
              put_byte({3'b110, ch[10:6]}, 1'b0);
              put_byte({2'b10, ch[5:0]}, 1'b0);
            end else begin
              put_byte({4'b1110, ch[15:12]}, 1'b0);
              put_byte({2'b10, ch[11:6]}, 1'b0);
              put_byte({2'b10, ch[5:0]}, 1'b0);
            end
          end
          OUT_CP1251: put_byte(ucs_to_win(ch), 1'b0);
          OUT_U16LE: begin
            put_byte(ch[7:0], 1'b0);
            put_byte(ch[15:8], 1'b0);
          end
          OUT_U16BE: begin
            put_byte(ch[15:8], 1'b0);
            put_byte(ch[7:0], 1'b0);
          end
          default: put_byte(ch[7:0], 1'b0);
        endcase
      end
    end

    if (last) begin
      p_accum = 16'h0000;
      p_need = 2'd0;
      put_byte(8'h00, 1'b1);
      if (p_out_code == OUT_U16LE || p_out_code == OUT_U16BE) put_byte(8'h00, 1'b1);
      p_written = 16'h0000;
    end

    if (want_q.size() > start) want_q[want_q.size() - 1].last = 1'b1;
  endfunction

  // input driver: one beat in flight, random gap after each accepted beat
  always @(posedge clk) begin : feed
    logic     vld;
    in_beat_t nb;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      feed_gap = 0;
    end else begin
      vld = in_tvalid;
      if (vld && in_tready) vld = 1'b0;
      if (!vld) begin
        if (feed_gap > 0) begin
          feed_gap--;
        end else if (beat_q.size() != 0) begin
          nb = beat_q.pop_front();
          in_tdata <= nb.data;
          in_tlast <= nb.last;
          vld = 1'b1;
          feed_gap = $urandom_range(0, in_max_gap);
        end
      end
      in_tvalid <= vld;
    end
  end

  // output sink: random stall after each accepted beat
  always @(posedge clk) begin : sink
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_tvalid && out_tready) sink_stall = $urandom_range(0, out_max_gap);
      if (sink_stall > 0) begin
        sink_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check
    out_byte_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        transcode_beat(in_tdata, in_tlast);
        beats_in++;
        if (in_tlast) strings_done++;
      end
      if (out_tvalid && out_tready) begin
        bytes_out++;
        if (want_q.size() == 0) begin
          $error("unexpected output beat: out_byte 0x%02h", out_tdata);
          errors++;
        end else begin
          w = want_q.pop_front();
          if (out_tdata !== w.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", w.data, out_tdata);
            errors++;
          end
          if (out_tuser[0] !== w.kept) begin
            $error("kept: expected %0b, got %0b", w.kept, out_tuser[0]);
            errors++;
          end
          if (out_tuser[1] !== w.term) begin
            $error("is_terminator: expected %0b, got %0b", w.term, out_tuser[1]);
            errors++;
          end
          if (out_tlast !== w.last) begin
            $error("last_out: expected %0b, got %0b", w.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_beat(logic [7:0] data, logic last);
    in_beat_t nb;
    nb.data = data;
    nb.last = last;
    beat_q.push_back(nb);
    queued_beats++;
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IN_CODE: begin
        p_in_code = val[1:0];
        p_accum = 16'h0000;
        p_need = 2'd0;
      end
      CFG_OUT_CODE: p_out_code = val[2:0];
      CFG_OUT_CAP:  p_cap = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // hold until every queued beat is in and every predicted byte is out
  task automatic settle();
    @(negedge clk);
    while (beat_q.size() != 0 || in_tvalid || want_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gen_string(logic [1:0] code);
    int          n;
    int          i;
    int          kind;
    logic [15:0] v;
    logic [7:0]  seq[$];
    n = $urandom_range(1, 10);
    for (i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      case (code)
        IN_UTF8: begin
          if (kind < 8) begin
            case ($urandom_range(0, 2))
              0: begin
                v = 16'($urandom_range(16'h0000, 16'h007F));
                seq.push_back(v[7:0]);
              end
              1: begin
                v = 16'($urandom_range(16'h0080, 16'h07FF));
                seq.push_back({3'b110, v[10:6]});
                seq.push_back({2'b10, v[5:0]});
              end
              default: begin
                v = 16'($urandom_range(16'h0800, 16'hFFFF));
                seq.push_back({4'b1110, v[15:12]});
                seq.push_back({2'b10, v[11:6]});
                seq.push_back({2'b10, v[5:0]});
              end
            endcase
          end else if (kind == 8) begin
            seq.push_back(8'($urandom_range(0, 255)));
          end else begin
            // broken: lead byte followed by a stray byte
            seq.push_back(8'($urandom_range(8'hC0, 8'hEF)));
            seq.push_back(8'($urandom_range(0, 255)));
          end
        end
        IN_U16LE: begin
          seq.push_back(8'($urandom_range(0, 255)));
          if (kind < 9) seq.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          if (kind < 5) begin
            seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
          end else if (kind == 5) begin
            case ($urandom_range(0, 3))
              0:       seq.push_back(8'hB2);
              1:       seq.push_back(8'hAF);
              2:       seq.push_back(8'hB3);
              default: seq.push_back(8'hBF);
            endcase
          end else begin
            seq.push_back(8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    for (i = 0; i < seq.size(); i++) add_beat(seq[i], i == seq.size() - 1);
  endtask

  initial begin : limit
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stim
    logic [1:0]  code_in;
    logic [2:0]  code_out;
    logic [15:0] cap;
    int          ph;
    int          i;
    int          mark;

    p_in_code = IN_UTF8;
    p_out_code = OUT_UTF8;
    p_cap = CAP_MAX;
    p_accum = 16'h0000;
    p_need = 2'd0;
    p_written = 16'h0000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset codes: UTF-8 in and out, boundaries and wrapping continuations
    in_max_gap = 10;
    out_max_gap = 10;
    add_beat(8'h00, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'hC2, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hDF, 1'b0);
    add_beat(8'hBF, 1'b0);
    add_beat(8'hE0, 1'b0);
    add_beat(8'hA0, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hEF, 1'b0);
    add_beat(8'hBF, 1'b0);
    add_beat(8'hBF, 1'b0);
    add_beat(8'hE0, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hE2, 1'b0);
    add_beat(8'h82, 1'b1);
    settle();

    set_reg(CFG_IN_CODE, {14'd0, IN_CP1251});
    set_reg(CFG_OUT_CODE, {13'd0, OUT_CP1251});
    add_beat(8'hC0, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hB2, 1'b0);
    add_beat(8'hAF, 1'b0);
    add_beat(8'hB3, 1'b0);
    add_beat(8'hBF, 1'b1);
    settle();

    set_reg(CFG_IN_CODE, {14'd0, IN_U16LE});
    set_reg(CFG_OUT_CODE, {13'd0, OUT_U16BE});
    add_beat(8'h34, 1'b0);
    add_beat(8'h12, 1'b0);
    add_beat(8'hFF, 1'b1);
    settle();

    // capacity cuts into a three-byte character
    set_reg(CFG_OUT_CODE, {13'd0, OUT_UTF8});
    set_reg(CFG_OUT_CAP, 16'd2);
    add_beat(8'h00, 1'b0);
    add_beat(8'h08, 1'b1);
    settle();

    set_reg(CFG_IN_CODE, {14'd0, IN_RAW});
    set_reg(CFG_OUT_CODE, {13'd0, OUT_SPARE_HI});
    set_reg(CFG_OUT_CAP, 16'd1);
    set_reg(CFG_SPARE, 16'hFFFF);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b1);
    settle();

    // code change drops a pending lead byte
    set_reg(CFG_IN_CODE, {14'd0, IN_UTF8});
    set_reg(CFG_OUT_CODE, {13'd0, OUT_UTF8});
    set_reg(CFG_OUT_CAP, CAP_MAX);
    add_beat(8'hE2, 1'b0);
    settle();
    set_reg(CFG_IN_CODE, {14'd0, IN_UTF8});
    add_beat(8'h82, 1'b1);
    settle();

    for (ph = 0; ph < 7; ph++) begin
      code_in = 2'($urandom_range(0, 3));
      code_out = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0:       cap = 16'($urandom_range(0, 16));
        1:       cap = CAP_MAX;
        2:       cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(8, 40));
      endcase
      in_max_gap = (ph % 3 == 2) ? 0 : 10;
      out_max_gap = (ph % 4 == 1) ? 0 : 10;
      set_reg(CFG_IN_CODE, {14'd0, code_in});
      set_reg(CFG_OUT_CODE, {13'd0, code_out});
      set_reg(CFG_OUT_CAP, cap);
      mark = queued_beats;
      while (queued_beats - mark < 25) gen_string(code_in);
      // leave a string open across the next register writes
      if ($urandom_range(0, 1) == 1) begin
        for (i = 0; i < 3; i++) add_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      settle();
    end

    $display("Covered %0d input beats in %0d strings, %0d output bytes, %0d register writes.",
             beats_in, strings_done, bytes_out, reg_writes);
    $display("All input and output codes, capacities 0 to max, and broken text.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tct_pkg.sv
rtl/tct_front.sv
rtl/tct_fifo.sv
rtl/tct_back.sv
rtl/text_codepage_transcoder_top.sv
tb/tb.sv
